// ----- design/wheel_goal_deadband_controller_macros.svh -----
// Assertion macros for the wheel goal deadband controller checker.
// Included by the checker only; no dependencies.
`ifndef WHEEL_GOAL_DEADBAND_CONTROLLER_MACROS_SVH
`define WHEEL_GOAL_DEADBAND_CONTROLLER_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define WGDC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked through reset
`define WGDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/wgdc_pkg.sv -----
// Package for the wheel goal deadband controller: action and register codes,
// fixed-point constants, result struct and the speed clamp. No dependencies.
package wgdc_pkg;

    // Action codes carried by an input item
    typedef enum logic [2:0] {
        ACT_NEW_TARGET  = 3'd0,
        ACT_MOVE        = 3'd1,
        ACT_ROTATE      = 3'd2,
        ACT_FINE_MOVE   = 3'd3,
        ACT_FINE_ROTATE = 3'd4
    } action_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_STEP_TOL  = 1'b0,
        CFG_ANGLE_TOL = 1'b1
    } cfg_index_t;

    localparam int TOL_W   = 10;
    localparam int SPEED_W = 11;
    localparam int S_W     = 18;   // working speed width, holds -(-32768)

    localparam logic [TOL_W-1:0] STEP_TOL_RESET  = 10'd10;
    localparam logic [TOL_W-1:0] ANGLE_TOL_RESET = 10'd2;

    // Q16 scales: steps per mm, steps per 1/16 degree
    localparam logic [19:0] MM_SCALE_Q16    = 20'd508799;
    localparam logic [19:0] DEG16_SCALE_Q16 = 20'd14708;
    localparam logic [36:0] ROUND_HALF      = 37'd32768;

    localparam logic signed [S_W-1:0] SPEED_LIMIT    = 18'sd1000;
    localparam logic signed [32:0]    FINE_BAND      = 33'sd100;
    localparam logic signed [S_W-1:0] FINE_MOVE_SLOW = 18'sd100;
    localparam logic signed [S_W-1:0] FINE_ROT_BIAS  = 18'sd10;

    // One result item
    typedef struct packed {
        logic                      done_res;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
        logic                      drive_update;
    } result_t;

    // Goal bookkeeping requested by the law for the current item
    typedef struct packed {
        logic        set_goal;
        logic        clear_goal;
        logic [31:0] goal_value;
    } goal_ctl_t;

    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [S_W-1:0] v
    );
        logic signed [S_W-1:0] c;
        begin
            if (v > SPEED_LIMIT) begin
                c = SPEED_LIMIT;
            end else if (v < -SPEED_LIMIT) begin
                c = -SPEED_LIMIT;
            end else begin
                c = v;
            end
            return c[SPEED_W-1:0];
        end
    endfunction

endpackage

// ----- design/wheel_goal_deadband_controller.sv -----
// Top level of the wheel goal deadband controller: input register, drive law,
// result register, goal state and tolerance registers. Uses wgdc_pkg and wgdc_law.
//
//   channel | ports        | fields (low bit first)
//   --------+--------------+------------------------------------------------
//   input   | s_t*         | action[2:0] amount[18:3] speed_request[34:19]
//           |              | left_count[66:35], zero fill to 72 bits
//   result  | m_t*         | drive_update[0] left_speed[11:1]
//           |              | right_speed[22:12] done_res[23]
//   config  | cfg_*        | 0 step_tolerance, 1 angle_tolerance
//
// One item per cycle sustained while the result is not stalled; each item passes
// the input register, then the multiply-and-compare law into the result register.
// The goal is updated as an item moves into the result register, so the next
// item sees it at once. Reset clears goal and both valid bits and sets the
// tolerances to 10 and 2 steps.
// A stalled result holds while one more item waits in the input register.
module wheel_goal_deadband_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action, amount, speed_request, left_count, zero fill
    input  logic [71:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // drive_update, left_speed, right_speed, done_res
    output logic [23:0]                   m_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [wgdc_pkg::TOL_W-1:0]    cfg_wdata
);
    import wgdc_pkg::*;

    logic               in_valid_reg, in_valid_next;
    logic [2:0]         action_reg;
    logic signed [15:0] amount_reg;
    logic signed [15:0] speed_reg;
    logic [31:0]        count_reg;

    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg;

    logic [31:0]        goal_steps_reg;
    logic               goal_latched_reg;
    logic [TOL_W-1:0]   step_tol_reg;
    logic [TOL_W-1:0]   angle_tol_reg;

    logic               s_accept;
    logic               advance;
    logic               load_out;
    result_t            law_result;
    goal_ctl_t          goal_ctl;

    // Handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign load_out = in_valid_reg && advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input item register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            action_reg <= s_tdata[2:0];
            amount_reg <= s_tdata[18:3];
            speed_reg  <= s_tdata[34:19];
            count_reg  <= s_tdata[66:35];
        end
    end

    wgdc_law u_law (
        .action          (action_reg),
        .amount          (amount_reg),
        .speed_request   (speed_reg),
        .left_count      (count_reg),
        .goal_steps      (goal_steps_reg),
        .goal_latched    (goal_latched_reg),
        .step_tolerance  (step_tol_reg),
        .angle_tolerance (angle_tol_reg),
        .result          (law_result),
        .goal_ctl        (goal_ctl)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= law_result;
        end
    end

    // Goal state, updated as an item leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_steps_reg   <= '0;
            goal_latched_reg <= 1'b0;
        end else if (load_out) begin
            if (goal_ctl.clear_goal) begin
                goal_latched_reg <= 1'b0;
            end else if (goal_ctl.set_goal) begin
                goal_latched_reg <= 1'b1;
                goal_steps_reg   <= goal_ctl.goal_value;
            end
        end
    end

    // Tolerance registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_tol_reg  <= STEP_TOL_RESET;
            angle_tol_reg <= ANGLE_TOL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STEP_TOL:  step_tol_reg  <= cfg_wdata;
                CFG_ANGLE_TOL: angle_tol_reg <= cfg_wdata;
            endcase
        end
    end

endmodule

// ----- design/wgdc_law.sv -----
// Goal latch arithmetic and three-way deadband drive law for one item.
// Uses wgdc_pkg; purely combinational, sits between the input and result registers.
module wgdc_law (
    input  logic [2:0]                     action,
    input  logic signed [15:0]             amount,
    input  logic signed [15:0]             speed_request,
    input  logic [31:0]                    left_count,
    input  logic [31:0]                    goal_steps,
    input  logic                           goal_latched,
    input  logic [wgdc_pkg::TOL_W-1:0]     step_tolerance,
    input  logic [wgdc_pkg::TOL_W-1:0]     angle_tolerance,
    output wgdc_pkg::result_t              result,
    output wgdc_pkg::goal_ctl_t            goal_ctl
);
    import wgdc_pkg::*;

    action_t               act;
    logic                  rotating;
    logic                  motion;
    logic [19:0]           scale;
    logic signed [36:0]    prod;
    logic [36:0]           mag;
    logic [20:0]           off_mag;
    logic [31:0]           off;
    logic [31:0]           err;
    logic signed [32:0]    err_x;
    logic signed [32:0]    tol_x;
    logic [31:0]           abs_err;
    logic                  big;
    logic signed [S_W-1:0] s;
    logic signed [S_W-1:0] neg_s;
    logic                  in_band;
    logic                  reverse;

    assign act = action_t'(action);

    always_comb begin
        unique case (act)
            ACT_MOVE, ACT_FINE_MOVE: begin
                motion   = 1'b1;
                rotating = 1'b0;
            end
            ACT_ROTATE, ACT_FINE_ROTATE: begin
                motion   = 1'b1;
                rotating = 1'b1;
            end
            default: begin
                motion   = 1'b0;
                rotating = 1'b0;
            end
        endcase
    end

    // Goal offset: amount * Q16 scale, half up when positive, truncated when negative
    assign scale   = rotating ? DEG16_SCALE_Q16 : MM_SCALE_Q16;
    assign prod    = 37'(amount) * $signed({17'd0, scale});
    assign mag     = prod[36] ? 37'(-prod) : 37'(prod) + ROUND_HALF;
    assign off_mag = mag[36:16];
    assign off     = prod[36] ? 32'(-{11'd0, off_mag}) : {11'd0, off_mag};

    // Error is the offset itself on the item that latches the goal
    assign err   = goal_latched ? (goal_steps - left_count) : off;
    assign err_x = {err[31], err};
    assign tol_x = (act == ACT_FINE_ROTATE) ? $signed({23'd0, angle_tolerance})
                                            : $signed({23'd0, step_tolerance});

    assign abs_err = err[31] ? (32'd0 - err) : err;
    assign big     = (err_x > FINE_BAND) || (err_x < -FINE_BAND);

    // Speed schedule
    always_comb begin
        unique case (act)
            ACT_FINE_MOVE:   s = big ? SPEED_LIMIT : FINE_MOVE_SLOW;
            ACT_FINE_ROTATE: s = big ? SPEED_LIMIT
                                     : $signed({10'd0, abs_err[7:0]}) + FINE_ROT_BIAS;
            default:         s = S_W'(speed_request);
        endcase
    end
    assign neg_s = -s;

    assign in_band = (err_x < tol_x) && (err_x > -tol_x);
    assign reverse = err_x < -tol_x;

    // Deadband law
    always_comb begin
        result = '0;
        if (motion) begin
            result.drive_update = 1'b1;
            priority if (in_band) begin
                result.done_res = 1'b1;
            end else if (reverse) begin
                result.left_speed  = clamp_speed(neg_s);
                result.right_speed = rotating ? clamp_speed(s) : clamp_speed(neg_s);
            end else begin
                result.left_speed  = clamp_speed(s);
                result.right_speed = rotating ? clamp_speed(neg_s) : clamp_speed(s);
            end
        end
    end

    assign goal_ctl.set_goal   = motion && !goal_latched;
    assign goal_ctl.clear_goal = (act == ACT_NEW_TARGET);
    assign goal_ctl.goal_value = left_count + off;

endmodule

// ----- design/wgdc_checker.sv -----
// Port-level checker for the wheel goal deadband controller, bound to the top.
// Uses the assertion macros header; watches the result channel over time.
`include "wheel_goal_deadband_controller_macros.svh"

module wgdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result item stays put
    `WGDC_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Reset empties the result register
    `WGDC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // Done means a drive update with both wheels stopped
    `WGDC_ASSERT(a_done_stop, aclk, aresetn, m_tvalid && m_tdata[23] |-> m_tdata[0] && (m_tdata[22:1] == 22'd0), "done with wheels moving")

    // No drive update carries no speeds and no done
    `WGDC_ASSERT(a_idle_zero, aclk, aresetn, m_tvalid && !m_tdata[0] |-> (m_tdata[23:1] == 23'd0), "non-drive item not zero")

    // Both wheel speeds stay within the limit
    `WGDC_ASSERT(a_speed_range, aclk, aresetn, m_tvalid |-> ($signed(m_tdata[11:1]) <= 11'sd1000) && ($signed(m_tdata[11:1]) >= -11'sd1000) && ($signed(m_tdata[22:12]) <= 11'sd1000) && ($signed(m_tdata[22:12]) >= -11'sd1000), "speed out of range")

endmodule

bind wheel_goal_deadband_controller wgdc_checker u_wgdc_checker (.*);
